// ----- src/lfu_pkg.sv -----
`default_nettype none

package lfu_pkg;

  localparam int ENTRIES    = 16;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = 16;
  localparam int CAP_BITS   = 5;
  localparam int CAP_RESET  = 16;

  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_BITS = IDX_BITS;
  localparam int OCC_BITS  = $clog2(ENTRIES + 1);
  localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [OCC_BITS-1:0]   occ_t;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_INSERT,
    ST_RESP
  } state_e;

  typedef struct packed {
    func_e  func;
    key_t   key;
    value_t value;
  } req_t;

  typedef struct packed {
    logic   hit;
    value_t read_value;
  } rsp_t;

  // One table operation per cycle, issued by the sequencer.
  typedef struct packed {
    logic   bump;
    logic   wr_value;
    logic   evict;
    logic   insert;
    idx_t   slot;
    key_t   key;
    value_t value;
  } tbl_cmd_t;

  typedef struct packed {
    logic   valid;
    key_t   key;
    value_t value;
    count_t count;
    rank_t  rank;
  } tbl_rd_t;

endpackage

`default_nettype wire

// ----- src/lfu_table.sv -----
`default_nettype none

module lfu_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lfu_pkg::tbl_cmd_t cmd_i,
  input  lfu_pkg::idx_t     rd_idx_i,
  output lfu_pkg::tbl_rd_t  rd_o
);
  import lfu_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  key_t   key_q   [ENTRIES];
  value_t value_q [ENTRIES];
  count_t count_q [ENTRIES];
  rank_t  rank_q  [ENTRIES];
  rank_t  rank_d  [ENTRIES];
  rank_t  sel_rank;

  // Valid entries adjust rank by the addressed slot's; an insert ages all.
  always_comb begin
    valid_d  = valid_q;
    sel_rank = rank_q[cmd_i.slot];
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (valid_q[i]) begin
        if (cmd_i.bump && (rank_q[i] < sel_rank)) begin
          rank_d[i] = rank_q[i] + rank_t'(1);
        end
        if (cmd_i.evict && (rank_q[i] > sel_rank)) begin
          rank_d[i] = rank_q[i] - rank_t'(1);
        end
        if (cmd_i.insert) begin
          rank_d[i] = rank_q[i] + rank_t'(1);
        end
      end
    end
    if (cmd_i.bump) begin
      rank_d[cmd_i.slot] = '0;
    end
    if (cmd_i.evict) begin
      valid_d[cmd_i.slot] = 1'b0;
    end
    if (cmd_i.insert) begin
      valid_d[cmd_i.slot] = 1'b1;
      rank_d[cmd_i.slot]  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_q[i] <= rank_d[i];
    end
    if (cmd_i.insert) begin
      key_q[cmd_i.slot]   <= cmd_i.key;
      value_q[cmd_i.slot] <= cmd_i.value;
      count_q[cmd_i.slot] <= count_t'(1);
    end
    if (cmd_i.bump) begin
      if (count_q[cmd_i.slot] != '1) begin
        count_q[cmd_i.slot] <= count_q[cmd_i.slot] + count_t'(1);
      end
      if (cmd_i.wr_value) begin
        value_q[cmd_i.slot] <= cmd_i.value;
      end
    end
  end

  always_comb begin
    rd_o.valid = valid_q[rd_idx_i];
    rd_o.key   = key_q[rd_idx_i];
    rd_o.value = value_q[rd_idx_i];
    rd_o.count = count_q[rd_idx_i];
    rd_o.rank  = rank_q[rd_idx_i];
  end

  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |-> !valid_q[cmd_i.slot])
    else $error("insert targets an occupied slot");

  a_bump_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.bump || cmd_i.evict) |-> valid_q[cmd_i.slot])
    else $error("bump or evict targets an empty slot");

  a_insert_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.insert |=> valid_q[$past(cmd_i.slot)])
    else $error("inserted slot did not become valid");

endmodule

`default_nettype wire

// ----- src/lfu_ctrl.sv -----
`default_nettype none

module lfu_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfu_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfu_pkg::rsp_t                 out_rsp_o,
  input  logic [lfu_pkg::CAP_BITS-1:0]  cap_i,
  output lfu_pkg::tbl_cmd_t             tbl_cmd_o,
  output lfu_pkg::idx_t                 rd_idx_o,
  input  lfu_pkg::tbl_rd_t              rd_i
);
  import lfu_pkg::*;

  localparam idx_t LAST_IDX = idx_t'(ENTRIES - 1);

  state_e state_q, state_d;
  req_t   req_q;
  idx_t   idx_q, slot_q, victim_q, free_q;
  logic   found_q, have_q, free_ok_q;
  occ_t   used_q;
  count_t best_cnt_q;
  rank_t  best_rank_q;
  rsp_t   res_q, out_q;
  logic   out_valid_q, out_valid_d;

  logic                cap_zero, full, is_put, do_bump, key_match, better, resp_load;
  logic [CMP_BITS-1:0] cap_w, cap_eff;

  always_comb begin
    cap_w    = CMP_BITS'(cap_i);
    cap_eff  = (cap_w > CMP_BITS'(ENTRIES)) ? CMP_BITS'(ENTRIES) : cap_w;
    cap_zero = (cap_i == '0);
    full     = (CMP_BITS'(used_q) >= cap_eff);
    is_put   = (req_q.func == FUNC_PUT);
    do_bump  = found_q && (!is_put || !cap_zero);
    key_match = rd_i.valid && !found_q && (rd_i.key == req_q.key);
    // Smallest count wins; among equal counts the larger rank is older.
    better = rd_i.valid && (!have_q || (rd_i.count < best_cnt_q) ||
             ((rd_i.count == best_cnt_q) && (rd_i.rank > best_rank_q)));
    resp_load = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_q == LAST_IDX) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_put && !cap_zero && !found_q) begin
          if (full && have_q) begin
            state_d = ST_EVICT;
          end else if (free_ok_q) begin
            state_d = ST_INSERT;
          end else begin
            state_d = ST_RESP;
          end
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_EVICT:  state_d = ST_INSERT;
      ST_INSERT: state_d = ST_RESP;
      ST_RESP: begin
        if (resp_load) state_d = ST_IDLE;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    rd_idx_o           = (state_q == ST_SCAN) ? idx_q : slot_q;
    tbl_cmd_o          = '0;
    tbl_cmd_o.key      = req_q.key;
    tbl_cmd_o.value    = req_q.value;
    tbl_cmd_o.slot     = slot_q;
    case (state_q)
      ST_DECIDE: begin
        tbl_cmd_o.bump     = do_bump;
        tbl_cmd_o.wr_value = is_put;
      end
      ST_EVICT: begin
        tbl_cmd_o.evict = 1'b1;
        tbl_cmd_o.slot  = victim_q;
      end
      ST_INSERT: begin
        tbl_cmd_o.insert = 1'b1;
        tbl_cmd_o.slot   = free_q;
      end
      default: begin
        tbl_cmd_o.bump = 1'b0;
      end
    endcase
    out_valid_d = resp_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
    out_valid_o = out_valid_q;
    out_rsp_o   = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_q     <= in_req_i;
          idx_q     <= '0;
          found_q   <= 1'b0;
          have_q    <= 1'b0;
          free_ok_q <= 1'b0;
          used_q    <= '0;
        end
      end
      ST_SCAN: begin
        idx_q <= idx_q + idx_t'(1);
        if (rd_i.valid) begin
          used_q <= used_q + occ_t'(1);
        end else if (!free_ok_q) begin
          free_ok_q <= 1'b1;
          free_q    <= idx_q;
        end
        if (key_match) begin
          found_q <= 1'b1;
          slot_q  <= idx_q;
        end
        if (better) begin
          have_q      <= 1'b1;
          victim_q    <= idx_q;
          best_cnt_q  <= rd_i.count;
          best_rank_q <= rd_i.rank;
        end
      end
      ST_DECIDE: begin
        res_q.hit        <= found_q;
        res_q.read_value <= (found_q && !is_put) ? rd_i.value : '0;
      end
      ST_EVICT: begin
        // The evicted slot may lie below the first empty slot seen in the scan.
        if (!free_ok_q || (victim_q < free_q)) begin
          free_q <= victim_q;
        end
        free_ok_q <= 1'b1;
      end
      ST_RESP: begin
        if (resp_load) out_q <= res_q;
      end
      default: begin
        out_q <= out_q;
      end
    endcase
  end

  a_evict_has_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVICT) |-> have_q)
    else $error("eviction without a victim");

endmodule

`default_nettype wire

// ----- src/lfu_cache_lru_tiebreak.sv -----
`default_nettype none

// Fully associative LFU key-value cache of 16 entries with least-recent tie
// break. Each word on the input channel is a get or a put; each produces
// exactly one response word. For each operation the sequencer reads the
// table one entry per cycle to find the key, count occupancy, locate the
// first empty slot and pick the eviction victim in a single pass, then
// makes the hit update or decision, evicts and inserts where a put needs
// it, and hands the response to the output register. A new word is
// accepted only when the sequencer is idle, from the cycle after the
// response is loaded, so a word waits until the last one is through; a
// receiver that holds off a waiting response can delay words further,
// since the next response cannot load. The output register lets the next
// operation start while a response still waits. The capacity register is
// written by cfg_we_i/cfg_wdata_i, resets to 16, and values above 16 act
// as 16; zero makes puts change nothing.
module lfu_cache_lru_tiebreak (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lfu_pkg::req_t                 in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lfu_pkg::rsp_t                 out_rsp_o,
  input  logic                          cfg_we_i,
  input  logic [lfu_pkg::CAP_BITS-1:0]  cfg_wdata_i
);
  import lfu_pkg::*;

  logic [CAP_BITS-1:0] cap_q;
  tbl_cmd_t            tbl_cmd;
  idx_t                rd_idx;
  tbl_rd_t             rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_BITS'(CAP_RESET);
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cap_i       (cap_q),
    .tbl_cmd_o   (tbl_cmd),
    .rd_idx_o    (rd_idx),
    .rd_i        (rd_data)
  );

  lfu_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (tbl_cmd),
    .rd_idx_i (rd_idx),
    .rd_o     (rd_data)
  );

endmodule

`default_nettype wire

// ----- bench/lfu_cache_checker.sv -----
`timescale 1ns / 100ps

module lfu_cache_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  lfu_pkg::req_t                in_req_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  lfu_pkg::rsp_t                out_rsp_i,
  input  logic                         cfg_we_i,
  input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata_i,
  output int                           mismatches_o,
  output int                           outstanding_o
);
  import lfu_pkg::*;

  // Shadow copy of the cache table.
  logic                slot_valid [ENTRIES];
  key_t                slot_key   [ENTRIES];
  value_t              slot_value [ENTRIES];
  count_t              slot_uses  [ENTRIES];
  rank_t               slot_age   [ENTRIES];
  logic [CAP_BITS-1:0] capacity;

  rsp_t due_responses [$];
  rsp_t oldest;
  int   mismatches = 0;

  assign mismatches_o = mismatches;

  task automatic report_mismatch(input string what);
    if (mismatches < 40) begin
      $display("%0t checker: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Rank 0 is the most recent; entries more recent than s age by one.
  function automatic void bump_slot(input int s);
    rank_t r;
    r = slot_age[s];
    if (slot_uses[s] != '1) begin
      slot_uses[s]++;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i] && slot_age[i] < r) begin
        slot_age[i]++;
      end
    end
    slot_age[s] = '0;
  endfunction

  function automatic rsp_t cache_access(input req_t r);
    rsp_t  rsp;
    int    hit_slot;
    int    free_slot;
    int    victim;
    int    occupied;
    int    limit;
    rank_t gone_rank;
    rsp       = '0;
    hit_slot  = -1;
    free_slot = -1;
    victim    = -1;
    occupied  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_valid[i]) begin
        occupied++;
        if (hit_slot < 0 && slot_key[i] == r.key) begin
          hit_slot = i;
        end
      end
    end
    rsp.hit = (hit_slot >= 0);
    limit = (int'(capacity) > ENTRIES) ? ENTRIES : int'(capacity);

    if (r.func == FUNC_GET) begin
      if (hit_slot >= 0) begin
        bump_slot(hit_slot);
        rsp.read_value = slot_value[hit_slot];
      end
    end else if (limit != 0) begin
      if (hit_slot >= 0) begin
        bump_slot(hit_slot);
        slot_value[hit_slot] = r.value;
      end else begin
        if (occupied >= limit) begin
          // Fewest uses goes first; among equal counts, the least recent.
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_uses[i] < slot_uses[victim] ||
                (slot_uses[i] == slot_uses[victim] && slot_age[i] > slot_age[victim]))) begin
              victim = i;
            end
          end
          if (victim >= 0) begin
            gone_rank = slot_age[victim];
            slot_valid[victim] = 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_valid[i] && slot_age[i] > gone_rank) begin
                slot_age[i]--;
              end
            end
          end
        end
        for (int i = 0; i < ENTRIES; i++) begin
          if (!slot_valid[i] && free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot >= 0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i]) begin
              slot_age[i]++;
            end
          end
          slot_valid[free_slot] = 1'b1;
          slot_key[free_slot]   = r.key;
          slot_value[free_slot] = r.value;
          slot_uses[free_slot]  = count_t'(1);
          slot_age[free_slot]   = '0;
        end
      end
    end
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_valid[i] = 1'b0;
      end
      capacity = CAP_BITS'(CAP_RESET);
      due_responses.delete();
      outstanding_o <= 0;
    end else begin
      if (cfg_we_i) begin
        capacity = cfg_wdata_i;
      end
      // Responses are matched before this edge's request is queued.
      if (out_valid_i && out_ready_i) begin
        if (due_responses.size() == 0) begin
          report_mismatch("response word with no request outstanding");
        end else begin
          oldest = due_responses.pop_front();
          if (out_rsp_i.hit !== oldest.hit) begin
            report_mismatch($sformatf("hit is %b, expected %b", out_rsp_i.hit, oldest.hit));
          end
          if (out_rsp_i.read_value !== oldest.read_value) begin
            report_mismatch($sformatf("read_value is %h, expected %h",
                                      out_rsp_i.read_value, oldest.read_value));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        due_responses.push_back(cache_access(in_req_i));
      end
      outstanding_o <= due_responses.size();
    end
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import lfu_pkg::*;

  localparam int STALL_LIMIT = 1000;

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                in_valid  = 1'b0;
  req_t                in_req    = '0;
  logic                out_ready = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CAP_BITS-1:0] cfg_wdata = '0;
  logic                idle_on   = 1'b1;

  logic in_ready;
  logic out_valid;
  rsp_t out_rsp;
  int   mismatches;
  int   outstanding;

  int   stall_left = 0;
  int   quiet_cycles = 0;
  key_t key_pool [24];
  key_t hot_key;

  always #5 clk_i = ~clk_i;

  lfu_cache_lru_tiebreak dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  lfu_cache_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_req_i      (in_req),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_rsp_i     (out_rsp),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // Receiver back-pressure in random bursts, started only while idle_on is set.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Valid stays high between back-to-back words; it only drops for a gap.
  task automatic send_word(input func_e f, input key_t k, input value_t v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= '{func: f, key: k, value: v};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic set_capacity(input logic [CAP_BITS-1:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Mostly keys from a small pool, skewed toward the first ones so that
  // use counts spread out; now and then a key from the whole range.
  task automatic run_phase(input int words);
    int   n_keys;
    int   pick;
    key_t k;
    n_keys = $urandom_range(2, 24);
    for (int i = 0; i < 24; i++) begin
      key_pool[i] = key_t'($urandom);
    end
    for (int i = 0; i < words; i++) begin
      pick = $urandom_range(0, n_keys - 1);
      if (pick > $urandom_range(0, n_keys - 1)) begin
        pick = $urandom_range(0, pick);
      end
      k = ($urandom_range(0, 9) == 0) ? key_t'($urandom) : key_pool[pick];
      send_word($urandom_range(0, 1) ? FUNC_PUT : FUNC_GET, k, value_t'($urandom));
    end
  endtask

  initial begin
    logic [CAP_BITS-1:0] caps [10];
    caps = '{5'd3, 5'd1, 5'd31, 5'd2, 5'd0, 5'd16, 5'd17, 5'd8, 5'd4, 5'd12};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(FUNC_GET, 16'h0000, 32'h0000_0000);
    send_word(FUNC_PUT, 16'h0000, 32'hFFFF_FFFF);
    send_word(FUNC_PUT, 16'hFFFF, 32'h0000_0000);
    send_word(FUNC_GET, 16'h0000, 32'hFFFF_FFFF);
    send_word(FUNC_GET, 16'hFFFF, 32'h0000_0000);
    // A put that hits answers zero and replaces the value.
    send_word(FUNC_PUT, 16'h0000, 32'h1234_5678);
    for (int k = 1; k <= 14; k++) begin
      send_word(FUNC_PUT, key_t'(k), value_t'($urandom));
    end
    // Table is full; the oldest of the single-use entries must go.
    send_word(FUNC_PUT, 16'h0100, value_t'($urandom));
    send_word(FUNC_GET, 16'h0001, 32'h0000_0000);
    send_word(FUNC_GET, 16'h0002, 32'h0000_0000);
    // With zero capacity a put changes nothing, even when it hits.
    set_capacity(5'd0);
    send_word(FUNC_PUT, 16'h0002, 32'hDEAD_BEEF);
    send_word(FUNC_PUT, 16'h0200, 32'h0000_0001);
    send_word(FUNC_GET, 16'h0002, 32'h0000_0000);
    set_capacity(5'd31);
    send_word(FUNC_PUT, 16'h0300, value_t'($urandom));
    send_word(FUNC_GET, 16'h0300, 32'h0000_0000);

    // The first phase lowers the capacity below the current occupancy.
    caps[9] = CAP_BITS'($urandom_range(0, 31));
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      idle_on <= ($urandom_range(0, 3) != 0);
      run_phase(190);
    end

    // Give one entry a use count well above the others, then let
    // evictions run around it.
    idle_on <= 1'b0;
    set_capacity(5'd16);
    hot_key = key_t'($urandom);
    send_word(FUNC_PUT, hot_key, value_t'($urandom));
    for (int i = 0; i < 20; i++) begin
      send_word(FUNC_GET, hot_key, 32'h0000_0000);
    end
    send_word(FUNC_PUT, hot_key, value_t'($urandom));
    set_capacity(5'd2);
    for (int i = 0; i < 6; i++) begin
      send_word(FUNC_PUT, key_t'($urandom), value_t'($urandom));
      send_word(FUNC_GET, hot_key, 32'h0000_0000);
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lfu_pkg.sv
src/lfu_table.sv
src/lfu_ctrl.sv
src/lfu_cache_lru_tiebreak.sv
bench/lfu_cache_checker.sv
bench/tb_top.sv
